// ===== hw/rtl/vmag_pkg.sv =====
// Package for the vector magnitude unit: widths, codes, pipeline control type.
// No dependencies; every other file of the block refers to it by scoped name.
`default_nettype none
package vmag_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int PORT_W     = 32;
    localparam int COUNT_W    = 3;
    localparam int MAG_W      = 33;
    localparam int NUM_COMP   = 4;

    localparam int SQ_W    = 2 * COMP_WIDTH;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = COMP_WIDTH + 1;
    localparam int TRIAL_W = 2 * ROOT_W;

    // abs, square, pair sum, final sum, one stage per root bit, output
    localparam int LATENCY = ROOT_W + 5;

    localparam logic [COUNT_W-1:0] COUNT_3D = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_4D = 3'd4;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BADSIZE = 1'b1;

    typedef logic [NUM_COMP-1:0][COMP_WIDTH-1:0] abs_vec_t;
    typedef logic [NUM_COMP-1:0][SQ_W-1:0]       sq_vec_t;

    typedef struct packed {
        logic valid;
        logic bad_size;
    } ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vmag_square.sv =====
// Front stages: component magnitudes, then their squares (two register stages).
// Depends on vmag_pkg.
`default_nettype none
module vmag_square (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_x,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_y,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_z,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_w,
    input  wire logic        [vmag_pkg::COUNT_W-1:0] element_count,
    output vmag_pkg::sq_vec_t                        sq,
    output vmag_pkg::ctl_t                           ctl
);

    logic [vmag_pkg::NUM_COMP-1:0][vmag_pkg::COMP_WIDTH-1:0] raw;
    vmag_pkg::abs_vec_t abs_next;
    vmag_pkg::abs_vec_t abs_reg;
    vmag_pkg::ctl_t     ctl1_next;
    vmag_pkg::ctl_t     ctl1_reg;
    vmag_pkg::sq_vec_t  sq_next;
    vmag_pkg::sq_vec_t  sq_reg;
    vmag_pkg::ctl_t     ctl2_reg;
    logic               use_w;

    assign raw[0] = comp_x[vmag_pkg::COMP_WIDTH-1:0];
    assign raw[1] = comp_y[vmag_pkg::COMP_WIDTH-1:0];
    assign raw[2] = comp_z[vmag_pkg::COMP_WIDTH-1:0];
    assign raw[3] = comp_w[vmag_pkg::COMP_WIDTH-1:0];
    assign use_w  = (element_count == vmag_pkg::COUNT_4D);

    always_comb
    begin
        for (int i = 0; i < vmag_pkg::NUM_COMP; i++)
        begin
            if (raw[i][vmag_pkg::COMP_WIDTH-1])
                abs_next[i] = ~raw[i] + vmag_pkg::COMP_WIDTH'(1);
            else
                abs_next[i] = raw[i];
        end
        // drop the fourth component unless the vector has four elements
        if (!use_w)
            abs_next[3] = '0;
        ctl1_next.valid    = in_valid;
        ctl1_next.bad_size = (element_count != vmag_pkg::COUNT_3D) && !use_w;
    end

    always_comb
    begin
        for (int i = 0; i < vmag_pkg::NUM_COMP; i++)
            sq_next[i] = vmag_pkg::SQ_W'(abs_reg[i]) * vmag_pkg::SQ_W'(abs_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg <= abs_next;
        sq_reg  <= sq_next;
    end

    assign sq  = sq_reg;
    assign ctl = ctl2_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vmag_sum.sv =====
// Adder tree for the four squares: pair sums, then the exact total (two stages).
// Depends on vmag_pkg.
`default_nettype none
module vmag_sum (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vmag_pkg::sq_vec_t             sq,
    input  wire vmag_pkg::ctl_t                ctl_in,
    output logic [vmag_pkg::SUM_W-1:0]         sum,
    output vmag_pkg::ctl_t                     ctl_out
);

    logic [vmag_pkg::SUM_W-1:0] pair0_next;
    logic [vmag_pkg::SUM_W-1:0] pair1_next;
    logic [vmag_pkg::SUM_W-1:0] pair0_reg;
    logic [vmag_pkg::SUM_W-1:0] pair1_reg;
    logic [vmag_pkg::SUM_W-1:0] sum_next;
    logic [vmag_pkg::SUM_W-1:0] sum_reg;
    vmag_pkg::ctl_t             ctl1_reg;
    vmag_pkg::ctl_t             ctl2_reg;

    assign pair0_next = vmag_pkg::SUM_W'(sq[0]) + vmag_pkg::SUM_W'(sq[1]);
    assign pair1_next = vmag_pkg::SUM_W'(sq[2]) + vmag_pkg::SUM_W'(sq[3]);
    assign sum_next   = pair0_reg + pair1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pair0_reg <= pair0_next;
        pair1_reg <= pair1_next;
        sum_reg   <= sum_next;
    end

    assign sum     = sum_reg;
    assign ctl_out = ctl2_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vmag_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on vmag_pkg.
`default_nettype none
module vmag_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [vmag_pkg::SUM_W-1:0]    radicand,
    input  wire vmag_pkg::ctl_t                ctl_in,
    output logic [vmag_pkg::ROOT_W-1:0]        root,
    output vmag_pkg::ctl_t                     ctl_out
);

    localparam int N = vmag_pkg::ROOT_W;

    logic [vmag_pkg::SUM_W-1:0]  rem_reg  [N];
    logic [vmag_pkg::ROOT_W-1:0] root_reg [N];
    vmag_pkg::ctl_t              ctl_reg  [N];

    logic [vmag_pkg::SUM_W-1:0]  stage_rem  [N+1];
    logic [vmag_pkg::ROOT_W-1:0] stage_root [N+1];
    vmag_pkg::ctl_t              stage_ctl  [N+1];

    assign stage_rem[0]  = radicand;
    assign stage_root[0] = '0;
    assign stage_ctl[0]  = ctl_in;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam int B = N - 1 - i;

        logic [vmag_pkg::TRIAL_W-1:0] trial;
        logic [vmag_pkg::TRIAL_W-1:0] rem_ext;
        logic [vmag_pkg::SUM_W-1:0]   rem_next;
        logic [vmag_pkg::ROOT_W-1:0]  root_next;

        always_comb
        begin
            trial   = (vmag_pkg::TRIAL_W'(stage_root[i]) << (B + 1))
                    | (vmag_pkg::TRIAL_W'(1) << (2 * B));
            rem_ext = vmag_pkg::TRIAL_W'(stage_rem[i]);
            if (rem_ext >= trial)
            begin
                rem_next  = vmag_pkg::SUM_W'(rem_ext - trial);
                root_next = stage_root[i] | (vmag_pkg::ROOT_W'(1) << B);
            end
            else
            begin
                rem_next  = stage_rem[i];
                root_next = stage_root[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else
                ctl_reg[i] <= stage_ctl[i];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            root_reg[i] <= root_next;
        end

        assign stage_rem[i+1]  = rem_reg[i];
        assign stage_root[i+1] = root_reg[i];
        assign stage_ctl[i+1]  = ctl_reg[i];
    end

    assign root    = stage_root[N];
    assign ctl_out = stage_ctl[N];

endmodule
`default_nettype wire

// ===== hw/rtl/vector_magnitude_unit.sv =====
// Top level of the vector magnitude unit: square, sum, root and output stages.
// Depends on vmag_pkg, vmag_square, vmag_sum and vmag_sqrt.
//
//  channel   handshake        payload
//  command   start / busy     comp_x comp_y comp_z comp_w element_count
//  result    done (strobe)    magnitude status
//
// One transfer may enter every cycle; busy is never raised.
// Pipeline stages: abs, square, two adder stages,
// one stage per root bit (33) in the square root pipeline, and the output register.
// Reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module vector_magnitude_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_x,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_y,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_z,
    input  wire logic signed [vmag_pkg::PORT_W-1:0]  comp_w,
    input  wire logic        [vmag_pkg::COUNT_W-1:0] element_count,
    output logic                                     done,
    output logic             [vmag_pkg::MAG_W-1:0]   magnitude,
    output logic                                     status
);

    vmag_pkg::sq_vec_t           sq;
    vmag_pkg::ctl_t              sq_ctl;
    logic [vmag_pkg::SUM_W-1:0]  sum;
    vmag_pkg::ctl_t              sum_ctl;
    logic [vmag_pkg::ROOT_W-1:0] root;
    vmag_pkg::ctl_t              root_ctl;

    logic                        done_reg;
    logic [vmag_pkg::MAG_W-1:0]  magnitude_next;
    logic [vmag_pkg::MAG_W-1:0]  magnitude_reg;
    logic                        status_next;
    logic                        status_reg;

    assign busy = 1'b0;

    vmag_square u_square (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start),
        .comp_x        (comp_x),
        .comp_y        (comp_y),
        .comp_z        (comp_z),
        .comp_w        (comp_w),
        .element_count (element_count),
        .sq            (sq),
        .ctl           (sq_ctl)
    );

    vmag_sum u_sum (
        .clk     (clk),
        .rst_n   (rst_n),
        .sq      (sq),
        .ctl_in  (sq_ctl),
        .sum     (sum),
        .ctl_out (sum_ctl)
    );

    vmag_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .radicand (sum),
        .ctl_in   (sum_ctl),
        .root     (root),
        .ctl_out  (root_ctl)
    );

    always_comb
    begin
        if (root_ctl.bad_size)
        begin
            magnitude_next = '0;
            status_next    = vmag_pkg::STATUS_BADSIZE;
        end
        else
        begin
            magnitude_next = vmag_pkg::MAG_W'(root);
            status_next    = vmag_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= root_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        magnitude_reg <= magnitude_next;
        status_reg    <= status_next;
    end

    assign done      = done_reg;
    assign magnitude = magnitude_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/vmag_checker.sv =====
// Port-level checks for the vector magnitude unit, bound to the top level.
// Depends on vmag_pkg and vector_magnitude_unit.
`default_nettype none
module vmag_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic [vmag_pkg::COUNT_W-1:0]    element_count,
    input wire logic                            done,
    input wire logic [vmag_pkg::MAG_W-1:0]      magnitude,
    input wire logic                            status
);

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(vmag_pkg::LATENCY) done)
        else $error("transfer accepted without a result at fixed latency");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, vmag_pkg::LATENCY))
        else $error("result without a matching accepted transfer");

    a_status_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ($past(element_count, vmag_pkg::LATENCY) != vmag_pkg::COUNT_3D
                  && $past(element_count, vmag_pkg::LATENCY) != vmag_pkg::COUNT_4D)))
        else $error("status does not follow the element count");

    a_bad_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == vmag_pkg::STATUS_BADSIZE) |-> (magnitude == '0))
        else $error("rejected vector with non-zero magnitude");

endmodule

bind vector_magnitude_unit vmag_checker u_vmag_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .element_count (element_count),
    .done          (done),
    .magnitude     (magnitude),
    .status        (status)
);
`default_nettype wire
